@@ rtl/rmst_pkg.sv @@
// Package for the radius match slot table.
// Shared constants, opcodes and the cell control struct; no dependencies.
package rmst_pkg;

   localparam int SLOT_COUNT_DEF  = 256;
   localparam int COORD_BITS_DEF  = 16;
   localparam int PORT_COORD_W    = 16;
   localparam int RANGE_W         = 16;
   localparam int LIM_W           = 2 * RANGE_W;
   localparam int SLOT_PORT_W     = 8;
   localparam int DIST_LAT        = 2;

   localparam logic [RANGE_W-1:0] RANGE_RESET = 16'd16;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic shift;
      logic load;
      logic clear;
   } cell_ctrl_type;

endpackage

@@ rtl/rmst_cell.sv @@
// One slot cell of the rotating slot ring: position and active flag.
// Depends on rmst_pkg for the cell control struct.
module rmst_cell #(
   parameter int COORD_BITS = rmst_pkg::COORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rmst_pkg::cell_ctrl_type ctrl,
   input  logic [COORD_BITS-1:0]   nb_x,
   input  logic [COORD_BITS-1:0]   nb_y,
   input  logic                    nb_active,
   input  logic [COORD_BITS-1:0]   ld_x,
   input  logic [COORD_BITS-1:0]   ld_y,
   input  logic                    ld_active,
   output logic [COORD_BITS-1:0]   x_q,
   output logic [COORD_BITS-1:0]   y_q,
   output logic                    active_q
);

   logic [COORD_BITS-1:0] x_ff, x_in;
   logic [COORD_BITS-1:0] y_ff, y_in;
   logic                  active_ff, active_in;

   always_comb begin
      x_in      = x_ff;
      y_in      = y_ff;
      active_in = active_ff;
      if (ctrl.load) begin
         x_in      = ld_x;
         y_in      = ld_y;
         active_in = ld_active;
      end else if (ctrl.shift) begin
         x_in      = nb_x;
         y_in      = nb_y;
         active_in = nb_active & ~ctrl.clear;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   assign x_q      = x_ff;
   assign y_q      = y_ff;
   assign active_q = active_ff;

endmodule

@@ rtl/rmst_dist.sv @@
// Two-stage squared distance compare at the head of the slot ring.
// Depends on rmst_pkg for range and limit widths.
module rmst_dist #(
   parameter int COORD_BITS = rmst_pkg::COORD_BITS_DEF,
   parameter int IDX_W      = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [COORD_BITS-1:0]        q_x,
   input  logic [COORD_BITS-1:0]        q_y,
   input  logic [COORD_BITS-1:0]        s_x,
   input  logic [COORD_BITS-1:0]        s_y,
   input  logic                         s_valid,
   input  logic [IDX_W-1:0]             s_idx,
   input  logic [rmst_pkg::RANGE_W-1:0] range,
   output logic                         hit,
   output logic [IDX_W-1:0]             hit_idx
);

   localparam int SQ_W  = 2 * COORD_BITS;
   localparam int CMP_W = (SQ_W > rmst_pkg::LIM_W) ? SQ_W : rmst_pkg::LIM_W;

   logic [COORD_BITS-1:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic                         v1_ff, v2_ff;
   logic [IDX_W-1:0]             idx1_ff, idx2_ff;
   logic [SQ_W-1:0]              dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic [rmst_pkg::LIM_W-1:0]   lim_ff, lim_in;
   logic [CMP_W-1:0]             dx2_ext, dy2_ext, lim_ext;

   always_comb begin
      dx_in  = (q_x >= s_x) ? (q_x - s_x) : (s_x - q_x);
      dy_in  = (q_y >= s_y) ? (q_y - s_y) : (s_y - q_y);
      dx2_in = SQ_W'(dx_ff) * SQ_W'(dx_ff);
      dy2_in = SQ_W'(dy_ff) * SQ_W'(dy_ff);
      lim_in = rmst_pkg::LIM_W'(range) * rmst_pkg::LIM_W'(range);
   end

   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      idx1_ff <= s_idx;
      dx2_ff  <= dx2_in;
      dy2_ff  <= dy2_in;
      lim_ff  <= lim_in;
      idx2_ff <= idx1_ff;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= s_valid;
         v2_ff <= v1_ff;
      end
   end

   assign dx2_ext = CMP_W'(dx2_ff);
   assign dy2_ext = CMP_W'(dy2_ff);
   assign lim_ext = CMP_W'(lim_ff);

   // dy^2 <= lim - dx^2 only looked at once dx^2 <= lim, so no wrap
   assign hit     = v2_ff & (dx2_ext <= lim_ext) & (dy2_ext <= (lim_ext - dx2_ext));
   assign hit_idx = idx2_ff;

endmodule

@@ rtl/radius_match_slot_table.sv @@
// Radius match slot table: a ring of slot cells rotating past one compare head.
// A write ends once every slot has passed the compare head; a query ends once the
// compare pipeline has drained too and the ring is back in place; then the result
// strobes for one cycle. One request at a time; busy is high while the ring turns.
// The rate is set by the single compare head that each slot passes once per turn.
// Reset (synchronous) clears all active flags and restores range_ff to RANGE_RESET (16).
// Depends on rmst_pkg, rmst_cell, rmst_dist.
module radius_match_slot_table #(
   parameter int SLOT_COUNT = rmst_pkg::SLOT_COUNT_DEF,
   parameter int COORD_BITS = rmst_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_opcode,
   input  logic [rmst_pkg::SLOT_PORT_W-1:0]      req_slot_index,
   input  logic [rmst_pkg::PORT_COORD_W-1:0]     req_pos_x,
   input  logic [rmst_pkg::PORT_COORD_W-1:0]     req_pos_y,
   input  logic                                  req_active_in,
   output logic                                  rsp_valid,
   output logic                                  rsp_found,
   output logic [rmst_pkg::SLOT_PORT_W-1:0]      rsp_matched_slot,
   input  logic                                  csr_we,
   input  logic [rmst_pkg::RANGE_W-1:0]          csr_wdata
);

   localparam int LAT      = rmst_pkg::DIST_LAT;
   localparam int ROT      = ((SLOT_COUNT + LAT + SLOT_COUNT - 1) / SLOT_COUNT) * SLOT_COUNT;
   localparam int STEP_W   = (ROT > 1) ? $clog2(ROT) : 1;
   localparam int SIDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int PW       = rmst_pkg::SLOT_PORT_W;
   localparam int CW       = rmst_pkg::PORT_COORD_W;
   localparam int CLR_SRC  = (SLOT_COUNT - (LAT % SLOT_COUNT)) % SLOT_COUNT;
   localparam int CLR_DST  = (CLR_SRC + SLOT_COUNT - 1) % SLOT_COUNT;
   localparam int LOAD_DST = SLOT_COUNT - 1;

   localparam logic [STEP_W-1:0] STEP_LAST_Q = STEP_W'(ROT - 1);
   localparam logic [STEP_W-1:0] STEP_LAST_W = STEP_W'(SLOT_COUNT - 1);
   localparam logic [STEP_W-1:0] STEP_SCAN   = STEP_W'(SLOT_COUNT);

   logic                         busy_ff, busy_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic                         op_ff, op_in;
   logic [PW-1:0]                idx_ff, idx_in;
   logic [COORD_BITS-1:0]        qx_ff, qx_in, qy_ff, qy_in;
   logic                         wact_ff, wact_in;
   logic                         found_ff, found_in;
   logic [SIDX_W-1:0]            slot_ff, slot_in;
   logic [rmst_pkg::RANGE_W-1:0] range_ff, range_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [PW-1:0]                rsp_slot_ff, rsp_slot_in;

   logic [COORD_BITS-1:0] cell_x [SLOT_COUNT];
   logic [COORD_BITS-1:0] cell_y [SLOT_COUNT];
   logic                  cell_act [SLOT_COUNT];

   logic                  accept, scanning, last_step, do_load, hit, take_hit, clear_now;
   logic [SIDX_W-1:0]     hit_idx, final_slot;
   logic [COORD_BITS+CW-1:0] px_ext, py_ext;
   logic [SIDX_W+PW-1:0]  slot_ext;

   assign accept    = start & ~busy_ff;
   assign scanning  = busy_ff & (step_ff < STEP_SCAN);
   assign last_step = busy_ff &
                      (step_ff == ((op_ff == rmst_pkg::OP_QUERY) ? STEP_LAST_Q : STEP_LAST_W));
   assign do_load   = scanning & (op_ff == rmst_pkg::OP_WRITE) &
                      (step_ff == STEP_W'(idx_ff));
   assign take_hit  = hit & ~found_ff;
   assign clear_now = take_hit;

   assign px_ext = {{COORD_BITS{1'b0}}, req_pos_x};
   assign py_ext = {{COORD_BITS{1'b0}}, req_pos_y};

   generate
      for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
         rmst_pkg::cell_ctrl_type ctrl;
         assign ctrl.shift = busy_ff;
         assign ctrl.load  = (k == LOAD_DST) ? do_load : 1'b0;
         assign ctrl.clear = (k == CLR_DST) ? clear_now : 1'b0;
         rmst_cell #(.COORD_BITS(COORD_BITS)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .nb_x      (cell_x[(k + 1) % SLOT_COUNT]),
            .nb_y      (cell_y[(k + 1) % SLOT_COUNT]),
            .nb_active (cell_act[(k + 1) % SLOT_COUNT]),
            .ld_x      (qx_ff),
            .ld_y      (qy_ff),
            .ld_active (wact_ff),
            .x_q       (cell_x[k]),
            .y_q       (cell_y[k]),
            .active_q  (cell_act[k])
         );
      end
   endgenerate

   rmst_dist #(.COORD_BITS(COORD_BITS), .IDX_W(SIDX_W)) u_dist (
      .clock   (clock),
      .reset   (reset),
      .q_x     (qx_ff),
      .q_y     (qy_ff),
      .s_x     (cell_x[0]),
      .s_y     (cell_y[0]),
      .s_valid (scanning & (op_ff == rmst_pkg::OP_QUERY) & cell_act[0]),
      .s_idx   (step_ff[SIDX_W-1:0]),
      .range   (range_ff),
      .hit     (hit),
      .hit_idx (hit_idx)
   );

   assign final_slot = found_ff ? slot_ff : hit_idx;
   assign slot_ext   = {{PW{1'b0}}, final_slot};

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      wact_in      = wact_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      range_in     = csr_we ? csr_wdata : range_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = rsp_found_ff;
      rsp_slot_in  = rsp_slot_ff;
      if (accept) begin
         busy_in  = 1'b1;
         step_in  = '0;
         op_in    = req_opcode;
         idx_in   = req_slot_index;
         qx_in    = px_ext[COORD_BITS-1:0];
         qy_in    = py_ext[COORD_BITS-1:0];
         wact_in  = req_active_in;
         found_in = 1'b0;
      end else if (busy_ff) begin
         step_in = step_ff + STEP_W'(1);
         if (take_hit) begin
            found_in = 1'b1;
            slot_in  = hit_idx;
         end
         if (last_step) begin
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_found_in = found_ff | take_hit;
            rsp_slot_in  = (found_ff | take_hit) ? slot_ext[PW-1:0] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      wact_ff     <= wact_in;
      slot_ff     <= slot_in;
      rsp_found_ff <= rsp_found_in;
      rsp_slot_ff <= rsp_slot_in;
      if (reset) begin
         busy_ff      <= 1'b0;
         found_ff     <= 1'b0;
         range_ff     <= rmst_pkg::RANGE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         found_ff     <= found_in;
         range_ff     <= range_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy             = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_matched_slot = rsp_slot_ff;

endmodule

@@ dv/radius_match_slot_table_tb.sv @@
`timescale 1ns / 1ps
// Testbench for radius_match_slot_table: directed and random slot writes and radius queries.
// A local mirror of the slot table predicts each result; depends on rmst_pkg and the RTL.
module radius_match_slot_table_tb;

   typedef struct packed {
      logic        opcode;
      logic [7:0]  slot;
      logic [15:0] x;
      logic [15:0] y;
      logic        active;
   } slot_request_type;

   typedef struct packed {
      logic       found;
      logic [7:0] slot;
   } match_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_opcode;
   logic [7:0]  req_slot_index;
   logic [15:0] req_pos_x;
   logic [15:0] req_pos_y;
   logic        req_active_in;
   logic        rsp_valid;
   logic        rsp_found;
   logic [7:0]  rsp_matched_slot;
   logic        csr_we;
   logic [15:0] csr_wdata;

   radius_match_slot_table dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_slot_index   (req_slot_index),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_active_in    (req_active_in),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_matched_slot (rsp_matched_slot),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   logic [15:0]      mirror_x [256];
   logic [15:0]      mirror_y [256];
   logic             mirror_active [256];
   logic [15:0]      mirror_range;
   match_result_type pending_results [$];
   match_result_type oldest;
   int               mismatches;
   int               leftovers;
   int               n_writes;
   int               n_queries;
   int               n_hits;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [15:0] clamp16(int v);
      if (v < 0) return 16'd0;
      if (v > 65535) return 16'hFFFF;
      return v[15:0];
   endfunction

   function automatic logic in_radius(logic [15:0] ax, logic [15:0] ay,
                                      logic [15:0] bx, logic [15:0] by,
                                      logic [15:0] r);
      logic [15:0] dx;
      logic [15:0] dy;
      logic [32:0] dist2;
      logic [32:0] lim;
      dx = (ax >= bx) ? ax - bx : bx - ax;
      dy = (ay >= by) ? ay - by : by - ay;
      dist2 = 33'(dx) * 33'(dx) + 33'(dy) * 33'(dy);
      lim = 33'(r) * 33'(r);
      return dist2 <= lim;
   endfunction

   // updates the mirror as the block would and returns the expected result
   function automatic match_result_type first_match_lookup(slot_request_type rq);
      match_result_type res;
      res = '0;
      if (rq.opcode == rmst_pkg::OP_WRITE) begin
         mirror_x[rq.slot] = rq.x;
         mirror_y[rq.slot] = rq.y;
         mirror_active[rq.slot] = rq.active;
      end else begin
         for (int i = 0; i < 256; i++) begin
            if (mirror_active[i] &&
                in_radius(rq.x, rq.y, mirror_x[i], mirror_y[i], mirror_range)) begin
               mirror_active[i] = 1'b0;
               res.found = 1'b1;
               res.slot = i[7:0];
               break;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: found=%0b slot=%0d", rsp_found, rsp_matched_slot);
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_found !== oldest.found || rsp_matched_slot !== oldest.slot) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected found=%0b slot=%0d, got found=%0b slot=%0d",
                           oldest.found, oldest.slot, rsp_found, rsp_matched_slot);
            end
         end
      end
   end

   task automatic send_request(slot_request_type rq, int gap);
      match_result_type res;
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode     <= rq.opcode;
      req_slot_index <= rq.slot;
      req_pos_x      <= rq.x;
      req_pos_y      <= rq.y;
      req_active_in  <= rq.active;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      res = first_match_lookup(rq);
      pending_results = {pending_results, res};
      if (rq.opcode == rmst_pkg::OP_WRITE) n_writes++;
      else n_queries++;
      if (res.found) n_hits++;
   endtask

   task automatic write_slot(logic [7:0] slot, logic [15:0] x, logic [15:0] y,
                             logic act, int gap);
      slot_request_type rq;
      rq = '{opcode: rmst_pkg::OP_WRITE, slot: slot, x: x, y: y, active: act};
      send_request(rq, gap);
   endtask

   task automatic query_at(logic [15:0] x, logic [15:0] y, int gap);
      slot_request_type rq;
      rq = '{opcode: rmst_pkg::OP_QUERY, slot: 8'($urandom), x: x, y: y,
             active: 1'($urandom)};
      send_request(rq, gap);
   endtask

   task automatic park_and_drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic set_range(logic [15:0] value);
      park_and_drain();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      mirror_range = value;
   endtask

   task automatic test_empty_table();
      query_at(16'h0000, 16'h0000, 0);
      query_at(16'hFFFF, 16'hFFFF, 1);
   endtask

   task automatic test_first_match_order();
      write_slot(8'd5, 16'd100, 16'd100, 1'b1, 0);
      write_slot(8'd3, 16'd100, 16'd100, 1'b1, 2);
      write_slot(8'd0, 16'd0, 16'd0, 1'b0, 0);
      query_at(16'd100, 16'd108, 0);
      query_at(16'd100, 16'd108, 3);
      query_at(16'd100, 16'd108, 0);
   endtask

   task automatic test_deactivate_by_write();
      write_slot(8'd7, 16'd500, 16'd500, 1'b1, 0);
      write_slot(8'd7, 16'd500, 16'd500, 1'b0, 1);
      query_at(16'd500, 16'd500, 0);
   endtask

   task automatic test_range_extremes();
      set_range(16'd0);
      write_slot(8'd255, 16'hFFFF, 16'hFFFF, 1'b1, 0);
      query_at(16'hFFFF, 16'hFFFE, 0);
      query_at(16'hFFFF, 16'hFFFF, 0);
      set_range(16'hFFFF);
      write_slot(8'd128, 16'hFFFF, 16'h0000, 1'b1, 0);
      write_slot(8'd1, 16'hFFFF, 16'hFFFF, 1'b1, 0);
      query_at(16'h0000, 16'h0000, 1);
      query_at(16'h0000, 16'h0000, 0);
      query_at(16'h8000, 16'h8000, 2);
   endtask

   task automatic test_random_phase(int count, logic [15:0] range, bit no_idle);
      int          gap;
      int          span;
      int          hot_x;
      int          hot_y;
      int          pick;
      logic [7:0]  slot;
      logic [15:0] x;
      logic [15:0] y;
      int          live [$];
      set_range(range);
      hot_x = $urandom_range(0, 65535);
      hot_y = $urandom_range(0, 65535);
      span = (range > 2000) ? 2000 : int'(range) + 2;
      repeat (count) begin
         gap = no_idle ? 0 : $urandom_range(0, 3);
         if ($urandom_range(0, 99) < 40) begin
            slot = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
            if ($urandom_range(0, 3) == 0) begin
               x = 16'($urandom);
               y = 16'($urandom);
            end else begin
               x = clamp16(hot_x + int'($urandom_range(0, 64)));
               y = clamp16(hot_y + int'($urandom_range(0, 64)));
            end
            write_slot(slot, x, y, $urandom_range(0, 4) != 0, gap);
         end else begin
            live.delete();
            for (int i = 0; i < 256; i++)
               if (mirror_active[i]) live = {live, i};
            if (live.size() != 0 && $urandom_range(0, 9) < 7) begin
               pick = live[$urandom_range(0, live.size() - 1)];
               if ($urandom_range(0, 9) < 3) begin
                  x = mirror_x[pick];
                  y = mirror_y[pick];
               end else begin
                  x = clamp16(int'(mirror_x[pick]) + int'($urandom_range(0, 2 * span)) - span);
                  y = clamp16(int'(mirror_y[pick]) + int'($urandom_range(0, 2 * span)) - span);
               end
            end else if ($urandom_range(0, 1) == 0) begin
               x = clamp16(hot_x + int'($urandom_range(0, 64)));
               y = clamp16(hot_y + int'($urandom_range(0, 64)));
            end else begin
               x = 16'($urandom);
               y = 16'($urandom);
            end
            query_at(x, y, gap);
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_opcode     = rmst_pkg::OP_WRITE;
      req_slot_index = '0;
      req_pos_x      = '0;
      req_pos_y      = '0;
      req_active_in  = 1'b0;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      mismatches     = 0;
      leftovers      = 0;
      n_writes       = 0;
      n_queries      = 0;
      n_hits         = 0;
      mirror_range   = rmst_pkg::RANGE_RESET;
      for (int i = 0; i < 256; i++) begin
         mirror_active[i] = 1'b0;
         mirror_x[i] = '0;
         mirror_y[i] = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_first_match_order();
      test_deactivate_by_write();
      test_range_extremes();

      test_random_phase(100, rmst_pkg::RANGE_RESET, 1'b0);
      test_random_phase(100, 16'd0, 1'b1);
      test_random_phase(100, 16'hFFFF, 1'b0);
      test_random_phase(100, 16'($urandom_range(1, 64)), 1'b1);
      test_random_phase(100, 16'($urandom_range(200, 4000)), 1'b0);
      test_random_phase(100, 16'($urandom), 1'b0);

      park_and_drain();
      repeat (40) @(posedge clock);
      leftovers = pending_results.size();

      $display("covered %0d slot writes and %0d radius queries, %0d of them matched",
               n_writes, n_queries, n_hits);
      $display("ranges 0, reset value, full scale and random; %0d mismatches, %0d left over",
               mismatches, leftovers);
      if (mismatches == 0 && leftovers == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
